// ----- rtl/tpmlpc_pkg.sv -----
package tpmlpc_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 48;

    localparam logic [2:0] ERROR_LIMIT_RESET = 3'd2;

    localparam logic [7:0] LPC_VERSION = 8'h01;
    localparam logic [7:0] CTL_DATA    = 8'h04;
    localparam logic [7:0] CTL_WTX     = 8'h10;
    localparam logic [7:0] CTL_ERROR   = 8'h20;
    localparam logic [7:0] NAK_CODE    = 8'h15;

    localparam logic [2:0] ST_RUNNING = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_ERRORS  = 3'd2;
    localparam logic [2:0] ST_TPM     = 3'd3;
    localparam logic [2:0] ST_BUS     = 3'd4;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_PAYLOAD = 2'd1,
        ACT_TPM     = 2'd2,
        ACT_BUS     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEND,
        PH_HDR,
        PH_DATA,
        PH_ERRB
    } phase_t;

    typedef enum logic [1:0] {
        BEAT_VERSION = 2'd0,
        BEAT_CONTROL = 2'd1,
        BEAT_LEN_HI  = 2'd2,
        BEAT_LEN_LO  = 2'd3
    } beat_t;

    // one queued job: a four-byte frame or a single result
    typedef struct packed {
        logic        is_frame;
        logic [7:0]  ctl;
        logic [15:0] len;
        logic        req;
        logic        tx_valid;
        logic        rx_valid;
        logic [7:0]  data;
        logic        done;
        logic [2:0]  status;
        logic [15:0] rlen;
        logic [7:0]  ebyte;
    } desc_t;

    function automatic desc_t make_frame(logic [7:0] ctl, logic [15:0] len, logic req);
        desc_t d;
        d          = '0;
        d.is_frame = 1'b1;
        d.ctl      = ctl;
        d.len      = len;
        d.req      = req;
        return d;
    endfunction

    function automatic desc_t make_done(logic [2:0] status, logic [15:0] rlen,
                                        logic [7:0] ebyte);
        desc_t d;
        d        = '0;
        d.done   = 1'b1;
        d.status = status;
        d.rlen   = rlen;
        d.ebyte  = ebyte;
        return d;
    endfunction

endpackage

// ----- rtl/tpmlpc_front.sv -----
module tpmlpc_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  item_valid,
    input  logic [tpmlpc_pkg::IN_TUSER_W-1:0]     item_user,
    input  logic [tpmlpc_pkg::IN_TDATA_W-1:0]     item_data,
    input  logic                                  cfg_valid,
    input  logic [2:0]                            cfg_data,
    input  logic                                  queue_full,
    output logic                                  item_ready,
    output logic                                  push,
    output tpmlpc_pkg::desc_t                     push_desc
);

    tpmlpc_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  header_index_reg, header_index_next;
    logic [7:0]  reply_version_reg, reply_version_next;
    logic [7:0]  reply_control_reg, reply_control_next;
    logic [15:0] reply_size_reg, reply_size_next;
    logic [15:0] payload_length_reg, payload_length_next;
    logic [15:0] receive_limit_reg, receive_limit_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [2:0]  error_count_reg, error_count_next;
    logic [2:0]  error_limit_reg;

    tpmlpc_pkg::action_t action;
    logic [15:0] send_length;
    logic [15:0] recv_limit;
    logic [7:0]  data_byte;
    logic        accept;
    logic [3:0]  err_inc;
    logic        err_fail;
    logic [15:0] bc_inc;
    logic [15:0] rsize_full;
    logic        hdr_invalid;

    assign action      = tpmlpc_pkg::action_t'(item_user[1:0]);
    assign send_length = item_data[15:0];
    assign recv_limit  = item_data[31:16];
    assign data_byte   = item_data[39:32];

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;
    assign err_inc    = {1'b0, error_count_reg} + 4'd1;
    assign err_fail   = err_inc > {1'b0, error_limit_reg};
    assign bc_inc     = byte_count_reg + 16'd1;
    assign rsize_full = {reply_size_reg[15:8], data_byte};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= tpmlpc_pkg::PH_IDLE;
            header_index_reg   <= '0;
            reply_version_reg  <= '0;
            reply_control_reg  <= '0;
            reply_size_reg     <= '0;
            payload_length_reg <= '0;
            receive_limit_reg  <= '0;
            byte_count_reg     <= '0;
            error_count_reg    <= '0;
            error_limit_reg    <= tpmlpc_pkg::ERROR_LIMIT_RESET;
        end else begin
            phase_reg          <= phase_next;
            header_index_reg   <= header_index_next;
            reply_version_reg  <= reply_version_next;
            reply_control_reg  <= reply_control_next;
            reply_size_reg     <= reply_size_next;
            payload_length_reg <= payload_length_next;
            receive_limit_reg  <= receive_limit_next;
            byte_count_reg     <= byte_count_next;
            error_count_reg    <= error_count_next;
            if (cfg_valid) begin
                error_limit_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        phase_next          = phase_reg;
        header_index_next   = header_index_reg;
        reply_version_next  = reply_version_reg;
        reply_control_next  = reply_control_reg;
        reply_size_next     = reply_size_reg;
        payload_length_next = payload_length_reg;
        receive_limit_next  = receive_limit_reg;
        byte_count_next     = byte_count_reg;
        error_count_next    = error_count_reg;
        push                = 1'b0;
        push_desc           = '0;
        hdr_invalid         = 1'b0;

        if (accept) begin
            case (action)
                tpmlpc_pkg::ACT_START: begin
                    payload_length_next = send_length;
                    receive_limit_next  = recv_limit;
                    error_count_next    = '0;
                    header_index_next   = '0;
                    byte_count_next     = '0;
                    push                = 1'b1;
                    if (recv_limit == 16'd0) begin
                        push_desc  = tpmlpc_pkg::make_done(tpmlpc_pkg::ST_ERRORS, '0, '0);
                        phase_next = tpmlpc_pkg::PH_IDLE;
                    end else begin
                        push_desc  = tpmlpc_pkg::make_frame(tpmlpc_pkg::CTL_DATA,
                                                            send_length,
                                                            send_length != 16'd0);
                        phase_next = (send_length != 16'd0) ? tpmlpc_pkg::PH_SEND
                                                            : tpmlpc_pkg::PH_HDR;
                    end
                end
                tpmlpc_pkg::ACT_PAYLOAD: begin
                    if (phase_reg == tpmlpc_pkg::PH_SEND) begin
                        push               = 1'b1;
                        push_desc.tx_valid = 1'b1;
                        push_desc.data     = data_byte;
                        byte_count_next    = bc_inc;
                        if (bc_inc >= payload_length_reg) begin
                            header_index_next = '0;
                            phase_next        = tpmlpc_pkg::PH_HDR;
                        end
                    end
                end
                tpmlpc_pkg::ACT_TPM: begin
                    case (phase_reg)
                        tpmlpc_pkg::PH_HDR: begin
                            header_index_next = header_index_reg + 2'd1;
                            case (tpmlpc_pkg::beat_t'(header_index_reg))
                                tpmlpc_pkg::BEAT_VERSION: reply_version_next = data_byte;
                                tpmlpc_pkg::BEAT_CONTROL: reply_control_next = data_byte;
                                tpmlpc_pkg::BEAT_LEN_HI:  reply_size_next = {data_byte, 8'h00};
                                default: begin
                                    reply_size_next   = rsize_full;
                                    header_index_next = '0;
                                    if (reply_version_reg != tpmlpc_pkg::LPC_VERSION) begin
                                        hdr_invalid = 1'b1;
                                    end else if (reply_control_reg == tpmlpc_pkg::CTL_DATA) begin
                                        if (rsize_full > receive_limit_reg) begin
                                            hdr_invalid = 1'b1;
                                        end else if (rsize_full == 16'd0) begin
                                            push       = 1'b1;
                                            push_desc  = tpmlpc_pkg::make_done(
                                                             tpmlpc_pkg::ST_OK, '0, '0);
                                            phase_next = tpmlpc_pkg::PH_IDLE;
                                        end else begin
                                            byte_count_next = '0;
                                            phase_next      = tpmlpc_pkg::PH_DATA;
                                        end
                                    end else if ((reply_control_reg & tpmlpc_pkg::CTL_ERROR)
                                                 != 8'd0) begin
                                        phase_next = tpmlpc_pkg::PH_ERRB;
                                    end else if ((reply_control_reg & tpmlpc_pkg::CTL_WTX)
                                                 != 8'd0) begin
                                        push      = 1'b1;
                                        push_desc = tpmlpc_pkg::make_frame(
                                                        tpmlpc_pkg::CTL_WTX, '0, 1'b0);
                                    end else begin
                                        hdr_invalid = 1'b1;
                                    end
                                    if (hdr_invalid) begin
                                        push = 1'b1;
                                        if (err_fail) begin
                                            push_desc  = tpmlpc_pkg::make_done(
                                                             tpmlpc_pkg::ST_ERRORS, '0, '0);
                                            phase_next = tpmlpc_pkg::PH_IDLE;
                                        end else begin
                                            error_count_next = err_inc[2:0];
                                            push_desc        = tpmlpc_pkg::make_frame(
                                                                   tpmlpc_pkg::CTL_ERROR,
                                                                   '0, 1'b0);
                                        end
                                    end
                                end
                            endcase
                        end
                        tpmlpc_pkg::PH_DATA: begin
                            push               = 1'b1;
                            push_desc.rx_valid = 1'b1;
                            push_desc.data     = data_byte;
                            byte_count_next    = bc_inc;
                            if (bc_inc >= reply_size_reg) begin
                                push_desc.done   = 1'b1;
                                push_desc.status = tpmlpc_pkg::ST_OK;
                                push_desc.rlen   = reply_size_reg;
                                phase_next       = tpmlpc_pkg::PH_IDLE;
                            end
                        end
                        tpmlpc_pkg::PH_ERRB: begin
                            push = 1'b1;
                            if (data_byte != tpmlpc_pkg::NAK_CODE) begin
                                push_desc  = tpmlpc_pkg::make_done(tpmlpc_pkg::ST_TPM, '0,
                                                                   data_byte);
                                phase_next = tpmlpc_pkg::PH_IDLE;
                            end else if (err_fail) begin
                                push_desc  = tpmlpc_pkg::make_done(tpmlpc_pkg::ST_ERRORS,
                                                                   '0, '0);
                                phase_next = tpmlpc_pkg::PH_IDLE;
                            end else begin
                                error_count_next  = err_inc[2:0];
                                header_index_next = '0;
                                byte_count_next   = '0;
                                push_desc         = tpmlpc_pkg::make_frame(
                                                        tpmlpc_pkg::CTL_DATA,
                                                        payload_length_reg,
                                                        payload_length_reg != 16'd0);
                                phase_next        = (payload_length_reg != 16'd0)
                                                    ? tpmlpc_pkg::PH_SEND
                                                    : tpmlpc_pkg::PH_HDR;
                            end
                        end
                        default: ;
                    endcase
                end
                default: begin
                    if (phase_reg != tpmlpc_pkg::PH_IDLE) begin
                        push       = 1'b1;
                        push_desc  = tpmlpc_pkg::make_done(tpmlpc_pkg::ST_BUS, '0, '0);
                        phase_next = tpmlpc_pkg::PH_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ----- rtl/tpmlpc_queue.sv -----
module tpmlpc_queue #(
    parameter int Depth = tpmlpc_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tpmlpc_pkg::desc_t push_desc,
    input  logic              pop,
    output tpmlpc_pkg::desc_t head,
    output logic              full,
    output logic              empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    tpmlpc_pkg::desc_t slot_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push, do_pop;

    assign full    = count_reg == FullCnt;
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ----- rtl/tpmlpc_back.sv -----
module tpmlpc_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tpmlpc_pkg::desc_t                    head,
    input  logic                                 empty,
    output logic                                 pop,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic [tpmlpc_pkg::OUT_TDATA_W-1:0]   res_data,
    output logic                                 res_last
);

    logic [1:0] beat_reg, beat_next;
    logic       res_valid_reg;
    logic [tpmlpc_pkg::OUT_TDATA_W-1:0] res_data_reg, res_data_next;
    logic       res_last_reg, res_last_next;
    logic       load;
    logic       last_beat;

    logic       txv, rxv, preq;
    logic [7:0] txb, rxb;

    assign load      = !empty && (!res_valid_reg || res_ready);
    assign last_beat = tpmlpc_pkg::beat_t'(beat_reg) == tpmlpc_pkg::BEAT_LEN_LO;
    assign pop       = load && (!head.is_frame || last_beat);

    always_comb begin
        beat_next = beat_reg;
        if (load) begin
            beat_next = pop ? 2'd0 : beat_reg + 2'd1;
        end
        txv  = head.tx_valid;
        txb  = head.tx_valid ? head.data : 8'h00;
        rxv  = head.rx_valid;
        rxb  = head.rx_valid ? head.data : 8'h00;
        preq = 1'b0;
        if (head.is_frame) begin
            txv  = 1'b1;
            preq = head.req && last_beat;
            case (tpmlpc_pkg::beat_t'(beat_reg))
                tpmlpc_pkg::BEAT_VERSION: txb = tpmlpc_pkg::LPC_VERSION;
                tpmlpc_pkg::BEAT_CONTROL: txb = head.ctl;
                tpmlpc_pkg::BEAT_LEN_HI:  txb = head.len[15:8];
                default:                  txb = head.len[7:0];
            endcase
        end
        // txv, txb, rxv, rxb, payload_request, done, status, reply_length, error byte
        res_data_next = {1'b0, head.ebyte, head.rlen, head.status, head.done, preq,
                         rxb, rxv, txb, txv};
        res_last_next = !head.is_frame || last_beat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg      <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            beat_reg <= beat_next;
            if (load) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_data_reg <= res_data_next;
            res_last_reg <= res_last_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;
    assign res_last  = res_last_reg;

endmodule

// ----- rtl/tpm_lpc_block_transport.sv -----
// TPM block transport framer/deframer. Each item on s_ is one event: start
// (tuser 0) sends a four-byte data header (an error result if recv_limit is 0),
// host payload bytes (1) go to the TPM, TPM bytes (2) are parsed as reply header
// and payload, bus failure (3) aborts. Results come out on m_ one per transfer,
// tlast marking the last one caused by an item. The front end takes one item per
// clock while its job queue has room; the back end drains the queue at one
// result per clock while m_tready allows, so a frame item (start, resend, WTX or
// NAK) gives four output beats, a single-result item one, and an ignored item or
// a reply header byte without a result none. The queue holds QueueDepth jobs so
// the input keeps flowing across short output stalls. The user must write
// error_limit on cfg_ only while no transaction runs; the block does not enforce it.
module tpm_lpc_block_transport #(
    parameter int QueueDepth = tpmlpc_pkg::QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // send_length, recv_limit, data_byte
    input  logic [tpmlpc_pkg::IN_TDATA_W-1:0]   s_tdata,
    // action
    input  logic [tpmlpc_pkg::IN_TUSER_W-1:0]   s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tx_valid, tx_byte, rx_valid, rx_byte, payload_request, done_res, status,
    // reply_length, tpm_error_byte, one zero pad bit
    output logic [tpmlpc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [2:0]                          cfg_data
);

    logic              q_push, q_pop, q_full, q_empty;
    tpmlpc_pkg::desc_t q_push_desc, q_head;

    assign cfg_ready = 1'b1;

    tpmlpc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_tvalid),
        .item_user  (s_tuser),
        .item_data  (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .queue_full (q_full),
        .item_ready (s_tready),
        .push       (q_push),
        .push_desc  (q_push_desc)
    );

    tpmlpc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (q_push_desc),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    tpmlpc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (m_tdata),
        .res_last  (m_tlast)
    );

    a_queue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_full && q_empty))
        else $error("queue full and empty together");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[19] |-> m_tlast)
        else $error("ending result not marked last");

    a_request_on_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18] |-> m_tlast && m_tdata[0])
        else $error("payload request outside last header byte");

    a_status_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[19] == (m_tdata[22:20] != tpmlpc_pkg::ST_RUNNING)))
        else $error("status and done disagree");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

endmodule
